// File: hw/rtl/ppu_pkg.sv
// ppu_pkg: types, constants and helpers for the perspective project/unproject unit
// used by ppu_div and perspective_project_unproject_unit; no dependencies
package ppu_pkg;

	localparam int SCREEN_WIDTH_DEF = 320;
	localparam int NUM_W = 66;
	localparam int DEN_W = 36;
	localparam int QBITS = 47;
	localparam int Q_W = QBITS + 1;
	localparam int DIV_LAT = QBITS + 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		CFG_VIEW_COS     = 3'd0,
		CFG_VIEW_SIN     = 3'd1,
		CFG_CAMERA_X     = 3'd2,
		CFG_CAMERA_Y     = 3'd3,
		CFG_CAMERA_Z     = 3'd4,
		CFG_FOCAL_LENGTH = 3'd5,
		CFG_HEIGHT_SCALE = 3'd6,
		CFG_PITCH_OFFSET = 3'd7
	} cfg_idx_t;

	typedef enum logic {
		KIND_PROJECT   = 1'b0,
		KIND_UNPROJECT = 1'b1
	} kind_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic signed [31:0] view_depth;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic signed [31:0] result_z;
		logic               in_front;
	} rsp_t;

	typedef struct packed {
		logic               kind;
		logic               front;
		logic               neg0;
		logic               neg1;
		logic signed [31:0] vd;
	} div_sb_t;

	localparam logic signed [67:0] SAT_MAX = 68'sh7FFFFFFF;
	localparam logic signed [67:0] SAT_MIN = -68'sh80000000;
	localparam logic [31:0] MINUS_ONE_Q16 = 32'hFFFF0000;

	function automatic logic [31:0] sat32(input logic signed [67:0] v);
		logic [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'h7FFFFFFF;
		end else if (v < SAT_MIN) begin
			r = 32'h80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/ppu_div.sv
// ppu_div: pipelined restoring divider, one quotient bit per stage
// result is round(num/den), halves up, capped at 2^47; uses ppu_pkg
module ppu_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ppu_pkg::NUM_W-1:0]    num,
	input  logic [ppu_pkg::DEN_W-1:0]    den,
	output logic [ppu_pkg::Q_W-1:0]      quo
);

	localparam int NW = ppu_pkg::NUM_W;
	localparam int DW = ppu_pkg::DEN_W;
	localparam int QB = ppu_pkg::QBITS;
	localparam int HW = NW - QB;

	logic [DW-1:0] den_s [0:QB];
	logic [DW-1:0] rem_s [0:QB];
	logic [QB-1:0] lo_s  [0:QB];
	logic [QB-1:0] q_s   [0:QB];
	logic          ovf_s [0:QB];
	logic          nz_s  [0:QB];

	logic [HW-1:0] hi;
	assign hi = num[NW-1:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			ovf_s[0] <= DW'(hi) >= den;
			nz_s[0]  <= |num;
			rem_s[0] <= DW'(hi);
			lo_s[0]  <= num[QB-1:0];
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_bit
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;
		assign t    = {rem_s[k-1], lo_s[k-1][QB-k]};
		assign diff = t - {1'b0, den_s[k-1]};
		assign ge   = t >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				nz_s[k]  <= nz_s[k-1];
				lo_s[k]  <= lo_s[k-1];
				rem_s[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
				q_s[k]   <= {q_s[k-1][QB-2:0], ge};
			end
		end
	end

	logic rnd;
	assign rnd = {rem_s[QB], 1'b0} >= {1'b0, den_s[QB]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (!nz_s[QB]) begin
				quo <= '0;
			end else if (ovf_s[QB]) begin
				quo <= {1'b1, {QB{1'b0}}};
			end else begin
				quo <= {1'b0, q_s[QB]} + ppu_pkg::Q_W'(rnd);
			end
		end
	end

endmodule

// File: hw/rtl/perspective_project_unproject_unit.sv
// perspective_project_unproject_unit: top level, camera registers and full pipeline
// depends on ppu_pkg and ppu_div
//
// Takes one request per cycle while the output is not stalled and returns one result
// per request, in order. The three divider lanes, which resolve one quotient bit per
// stage, make up most of the pipeline. The whole pipeline holds while a result waits
// at the output; item_ready is high when no result is valid or result_ready is high.
// Camera registers must be written only while the pipeline is empty.
module perspective_project_unproject_unit #(
	parameter int SCREEN_WIDTH = ppu_pkg::SCREEN_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  ppu_pkg::req_t                   item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output ppu_pkg::rsp_t                   result,
	input  logic                            cfg_we,
	input  ppu_pkg::cfg_idx_t               cfg_index,
	input  logic [ppu_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int NW = ppu_pkg::NUM_W;
	localparam int DW = ppu_pkg::DEN_W;
	localparam int QW = ppu_pkg::Q_W;
	localparam int LAT = ppu_pkg::DIV_LAT;
	localparam logic signed [16:0] HW_PIX = 17'(SCREEN_WIDTH / 2);
	localparam logic signed [67:0] HW_Q16 = 68'(SCREEN_WIDTH / 2) <<< 16;

	// camera registers
	logic signed [15:0] cos_q, sin_q, pitch_q;
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [30:0] focal_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= 16'sd16384;
			sin_q    <= '0;
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			cam_z_q  <= '0;
			focal_q  <= 31'd10485760;
			height_q <= 31'd10485760;
			pitch_q  <= 16'sd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppu_pkg::CFG_VIEW_COS:     cos_q    <= cfg_data[15:0];
				ppu_pkg::CFG_VIEW_SIN:     sin_q    <= cfg_data[15:0];
				ppu_pkg::CFG_CAMERA_X:     cam_x_q  <= cfg_data;
				ppu_pkg::CFG_CAMERA_Y:     cam_y_q  <= cfg_data;
				ppu_pkg::CFG_CAMERA_Z:     cam_z_q  <= cfg_data;
				ppu_pkg::CFG_FOCAL_LENGTH: focal_q  <= cfg_data[30:0];
				ppu_pkg::CFG_HEIGHT_SCALE: height_q <= cfg_data[30:0];
				ppu_pkg::CFG_PITCH_OFFSET: pitch_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic advance;
	assign advance    = !result_valid || result_ready;
	assign item_ready = advance;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_p1;
	logic [LAT-1:0] v_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_d  <= '0;
			v_p1 <= 1'b0;
			result_valid <= 1'b0;
		end else if (advance) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_d  <= {v_d[LAT-2:0], v_s4};
			v_p1 <= v_d[LAT-1];
			result_valid <= v_p1;
		end
	end

	// stage 1: offsets
	logic               kind_s1;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic signed [16:0] nx_s1, ny_s1;
	logic signed [31:0] vd_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1 <= item.kind;
			dx_s1   <= 33'(item.world_x) - 33'(cam_x_q);
			dy_s1   <= 33'(item.world_y) - 33'(cam_y_q);
			dz_s1   <= 33'(item.world_z) - 33'(cam_z_q);
			nx_s1   <= 17'(item.pixel_x) - HW_PIX;
			ny_s1   <= 17'(item.pixel_y) - 17'(pitch_q);
			vd_s1   <= item.view_depth;
		end
	end

	// stage 2: rotation and pixel products
	logic               kind_s2;
	logic signed [48:0] xc_s2, zs_s2, zc_s2, xs_s2, pnx_s2, pny_s2;
	logic signed [32:0] dy_s2;
	logic signed [31:0] vd_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s2 <= kind_s1;
			xc_s2   <= 49'(dx_s1) * 49'(cos_q);
			zs_s2   <= 49'(dz_s1) * 49'(sin_q);
			zc_s2   <= 49'(dz_s1) * 49'(cos_q);
			xs_s2   <= 49'(dx_s1) * 49'(sin_q);
			pnx_s2  <= 49'(nx_s1) * 49'(vd_s1);
			pny_s2  <= 49'(ny_s1) * 49'(vd_s1);
			dy_s2   <= dy_s1;
			vd_s2   <= vd_s1;
		end
	end

	// stage 3: view coordinates, depth test, magnitudes
	logic signed [49:0] sum_x, sum_z;
	logic signed [35:0] vx, vz;
	assign sum_x = 50'(xc_s2) + 50'(zs_s2) + 50'sd8192;
	assign sum_z = 50'(zc_s2) - 50'(xs_s2) + 50'sd8192;
	assign vx = 36'(sum_x >>> 14);
	assign vz = 36'(sum_z >>> 14);

	logic               kind_s3, front_s3, sx_s3, sy_s3, snx_s3, sny_s3;
	logic [35:0]        ax_s3;
	logic [32:0]        ady_s3;
	logic [48:0]        anx_s3, any_s3;
	logic signed [35:0] vz_s3;
	logic signed [31:0] vd_s3;

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s3  <= kind_s2;
			front_s3 <= kind_s2 || (vz >= 36'sd65536);
			sx_s3    <= vx[35];
			ax_s3    <= vx[35] ? 36'(-vx) : 36'(vx);
			sy_s3    <= dy_s2[32];
			ady_s3   <= dy_s2[32] ? 33'(-dy_s2) : 33'(dy_s2);
			snx_s3   <= pnx_s2[48];
			anx_s3   <= pnx_s2[48] ? 49'(-pnx_s2) : 49'(pnx_s2);
			sny_s3   <= pny_s2[48];
			any_s3   <= pny_s2[48] ? 49'(-pny_s2) : 49'(pny_s2);
			vz_s3    <= vz;
			vd_s3    <= vd_s2;
		end
	end

	// stage 4: dividend and divisor per lane
	logic [66:0] pfx, pfy;
	assign pfx = 67'(ax_s3) * 67'(focal_q);
	assign pfy = 67'(ady_s3) * 67'(height_q);

	logic [NW-1:0] n0_s4, n1_s4, n2_s4;
	logic [DW-1:0] d0_s4, d1_s4, d2_s4;
	ppu_pkg::div_sb_t sb_s4;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (kind_s3 == ppu_pkg::KIND_UNPROJECT) begin
				n0_s4 <= NW'({anx_s3, 16'b0});
				n1_s4 <= NW'({any_s3, 16'b0});
				n2_s4 <= '0;
				d0_s4 <= DW'(focal_q);
				d1_s4 <= DW'(height_q);
				sb_s4.neg0 <= snx_s3;
				sb_s4.neg1 <= sny_s3;
			end else begin
				n0_s4 <= pfx[NW-1:0];
				n1_s4 <= pfy[NW-1:0];
				n2_s4 <= NW'(64'h1_0000_0000);
				d0_s4 <= vz_s3;
				d1_s4 <= vz_s3;
				sb_s4.neg0 <= sx_s3;
				sb_s4.neg1 <= sy_s3;
			end
			d2_s4       <= vz_s3;
			sb_s4.kind  <= kind_s3;
			sb_s4.front <= front_s3;
			sb_s4.vd    <= vd_s3;
		end
	end

	// divider lanes
	logic [QW-1:0] q0, q1, q2;

	ppu_div u_div0 (.clk(clk), .en(advance), .num(n0_s4), .den(d0_s4), .quo(q0));
	ppu_div u_div1 (.clk(clk), .en(advance), .num(n1_s4), .den(d1_s4), .quo(q1));
	ppu_div u_div2 (.clk(clk), .en(advance), .num(n2_s4), .den(d2_s4), .quo(q2));

	ppu_pkg::div_sb_t sb_d [0:LAT-1];

	always_ff @(posedge clk) begin
		if (advance) begin
			sb_d[0] <= sb_s4;
			for (int i = 1; i < LAT; i++) begin
				sb_d[i] <= sb_d[i-1];
			end
		end
	end

	// post stage 1: signs and back-rotation products
	logic signed [48:0] sq0, sq1;
	assign sq0 = sb_d[LAT-1].neg0 ? -49'(q0) : 49'(q0);
	assign sq1 = sb_d[LAT-1].neg1 ? -49'(q1) : 49'(q1);

	logic               kind_p1, front_p1;
	logic signed [48:0] sq0_p1, sq1_p1;
	logic [QW-1:0]      q2_p1;
	logic signed [64:0] xc_p1, xs_p1;
	logic signed [47:0] ds_p1, dc_p1;

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_p1  <= sb_d[LAT-1].kind;
			front_p1 <= sb_d[LAT-1].front;
			sq0_p1   <= sq0;
			sq1_p1   <= sq1;
			q2_p1    <= q2;
			xc_p1    <= 65'(sq0) * 65'(cos_q);
			xs_p1    <= 65'(sq0) * 65'(sin_q);
			ds_p1    <= 48'(sb_d[LAT-1].vd) * 48'(sin_q);
			dc_p1    <= 48'(sb_d[LAT-1].vd) * 48'(cos_q);
		end
	end

	// post stage 2: final sums and saturation
	logic signed [67:0] ux, uz, uy, px, py, pz;
	assign ux = ((68'(xc_p1) - 68'(ds_p1) + 68'sd8192) >>> 14) + 68'(cam_x_q);
	assign uz = ((68'(xs_p1) + 68'(dc_p1) + 68'sd8192) >>> 14) + 68'(cam_z_q);
	assign uy = 68'(sq1_p1) + 68'(cam_y_q);
	assign px = HW_Q16 + 68'(sq0_p1);
	assign py = (68'(pitch_q) <<< 16) + 68'(sq1_p1);
	assign pz = 68'(q2_p1);

	always_ff @(posedge clk) begin
		if (advance) begin
			if (kind_p1 == ppu_pkg::KIND_UNPROJECT) begin
				result.result_x <= ppu_pkg::sat32(ux);
				result.result_y <= ppu_pkg::sat32(uy);
				result.result_z <= ppu_pkg::sat32(uz);
				result.in_front <= 1'b1;
			end else if (front_p1) begin
				result.result_x <= ppu_pkg::sat32(px);
				result.result_y <= ppu_pkg::sat32(py);
				result.result_z <= ppu_pkg::sat32(pz);
				result.in_front <= 1'b1;
			end else begin
				result.result_x <= ppu_pkg::MINUS_ONE_Q16;
				result.result_y <= ppu_pkg::MINUS_ONE_Q16;
				result.result_z <= ppu_pkg::MINUS_ONE_Q16;
				result.in_front <= 1'b0;
			end
		end
	end

	a_behind_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.in_front) |->
			(result.result_x == ppu_pkg::MINUS_ONE_Q16 &&
			 result.result_y == ppu_pkg::MINUS_ONE_Q16 &&
			 result.result_z == ppu_pkg::MINUS_ONE_Q16))
		else $error("behind-camera result not -1.0");

	a_unproject_front: assert property (@(posedge clk) disable iff (!arst_n)
		(v_d[LAT-1] && sb_d[LAT-1].kind) |-> sb_d[LAT-1].front)
		else $error("unprojection lost in_front");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable({v_s1, v_s2, v_s3, v_s4, v_d, v_p1}))
		else $error("pipeline moved during stall");

endmodule

// File: sim/perspective_project_unproject_unit_tb.sv
// perspective_project_unproject_unit_tb: directed and randomized self-checking bench for the
// project/unproject unit, with an in-order camera-model scoreboard
// depends on ppu_pkg and perspective_project_unproject_unit
module perspective_project_unproject_unit_tb;
	import ppu_pkg::*;

	localparam int SW = 320;
	localparam int DRAIN = 70;
	localparam int LIMIT = 2000000;

	class camera_scoreboard;
		longint vcos, vsin, cam_x, cam_y, cam_z, pitch;
		logic [127:0] focal, hscale;
		rsp_t expected_q[$];
		int errors;

		function new();
			vcos = 16384; vsin = 0; cam_x = 0; cam_y = 0; cam_z = 0;
			focal = 10485760; hscale = 10485760; pitch = 100; errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [31:0] v);
			case (idx)
				CFG_VIEW_COS: vcos = longint'($signed(v[15:0]));
				CFG_VIEW_SIN: vsin = longint'($signed(v[15:0]));
				CFG_CAMERA_X: cam_x = longint'($signed(v));
				CFG_CAMERA_Y: cam_y = longint'($signed(v));
				CFG_CAMERA_Z: cam_z = longint'($signed(v));
				CFG_FOCAL_LENGTH: focal = {97'b0, v[30:0]};
				CFG_HEIGHT_SCALE: hscale = {97'b0, v[30:0]};
				CFG_PITCH_OFFSET: pitch = longint'($signed(v[15:0]));
				default: ;
			endcase
		endfunction

		function logic [127:0] round_quot(logic [127:0] n, logic [127:0] d, logic [127:0] cap);
			logic [127:0] q, r;
			if (d == 0)
				return (n != 0) ? cap : 128'd0;
			q = n / d;
			r = n - q * d;
			if (r >= d - r)
				q = q + 1;
			if (q > cap)
				q = cap;
			return q;
		endfunction

		function longint signed_quot(longint a, logic [127:0] m, int s, logic [127:0] d,
				logic [127:0] cap);
			logic [127:0] mag, q;
			mag = (a < 0) ? {64'b0, 64'(-a)} : {64'b0, 64'(a)};
			q = round_quot((mag * m) << s, d, cap);
			return (a < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function logic [31:0] clamp32(longint v);
			if (v > 64'sd2147483647)
				return 32'h7FFFFFFF;
			if (v < -64'sd2147483648)
				return 32'h80000000;
			return v[31:0];
		endfunction

		function rsp_t transform(req_t r);
			rsp_t o;
			longint dx, dy, dz, vx, vy, vz, rx, ry, rz, nx, ny;
			o.in_front = 1'b1;
			if (r.kind == KIND_PROJECT) begin
				dx = longint'(r.world_x) - cam_x;
				dy = longint'(r.world_y) - cam_y;
				dz = longint'(r.world_z) - cam_z;
				vx = (dx * vcos + dz * vsin + 8192) >>> 14;
				vz = (dz * vcos - dx * vsin + 8192) >>> 14;
				if (vz >= 65536) begin
					rz = longint'(round_quot(128'd1 << 32, 128'(vz), 128'd1 << 40));
					rx = (SW / 2) * 65536 + signed_quot(vx, focal, 0, 128'(vz), 128'd1 << 40);
					ry = pitch * 65536 + signed_quot(dy, hscale, 0, 128'(vz), 128'd1 << 40);
				end else begin
					rx = -65536; ry = -65536; rz = -65536;
					o.in_front = 1'b0;
				end
			end else begin
				vz = longint'(r.view_depth);
				nx = longint'(r.pixel_x) - SW / 2;
				ny = longint'(r.pixel_y) - pitch;
				vx = signed_quot(nx * vz, 128'd1, 16, focal, 128'd1 << 47);
				vy = signed_quot(ny * vz, 128'd1, 16, hscale, 128'd1 << 47);
				rx = ((vx * vcos - vz * vsin + 8192) >>> 14) + cam_x;
				rz = ((vx * vsin + vz * vcos + 8192) >>> 14) + cam_z;
				ry = vy + cam_y;
			end
			o.result_x = clamp32(rx);
			o.result_y = clamp32(ry);
			o.result_z = clamp32(rz);
			return o;
		endfunction

		function void note_request(req_t r);
			expected_q.push_back(transform(r));
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
				return;
			end
			e = expected_q.pop_front();
			if (got.result_x !== e.result_x || got.result_y !== e.result_y ||
					got.result_z !== e.result_z || got.in_front !== e.in_front) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp x=%h y=%h z=%h f=%b got x=%h y=%h z=%h f=%b",
						e.result_x, e.result_y, e.result_z, e.in_front,
						got.result_x, got.result_y, got.result_z, got.in_front);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	req_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	rsp_t result;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_VIEW_COS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	camera_scoreboard sb = new();
	int cycles = 0;
	int stall_left = 0;
	bit no_stall = 1'b0;

	perspective_project_unproject_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			sb.note_request(item);
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// output-side backpressure
	always @(posedge clk) begin
		if (!arst_n || no_stall) begin
			result_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
				: $urandom_range(0, 2);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic idle_gap();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2: n = $urandom_range(1, 3);
			3: n = $urandom_range(8, 30);
			default: n = 0;
		endcase
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_request(req_t r);
		idle_gap();
		item_valid <= 1'b1;
		item <= r;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic write_camera(logic [31:0] c, logic [31:0] s, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] f, logic [31:0] h, logic [31:0] p);
		write_reg(CFG_VIEW_COS, c);
		write_reg(CFG_VIEW_SIN, s);
		write_reg(CFG_CAMERA_X, x);
		write_reg(CFG_CAMERA_Y, y);
		write_reg(CFG_CAMERA_Z, z);
		write_reg(CFG_FOCAL_LENGTH, f);
		write_reg(CFG_HEIGHT_SCALE, h);
		write_reg(CFG_PITCH_OFFSET, p);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic req_t random_request();
		req_t r;
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = bits[$bits(req_t)-1:0];
		r.kind = 1'($urandom_range(0, 1));
		if (r.kind == KIND_PROJECT && $urandom_range(0, 3) != 0) begin
			// points near the camera so most land in front
			r.world_x = 32'(sb.cam_x + $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23));
			r.world_y = 32'(sb.cam_y + $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23));
			r.world_z = 32'(sb.cam_z + $signed(32'($urandom_range(0, 1 << 25))) - (1 << 22));
		end else if (r.kind == KIND_UNPROJECT && $urandom_range(0, 1) != 0) begin
			r.pixel_x = 16'($urandom_range(0, 319));
			r.pixel_y = 16'($urandom_range(0, 199));
			r.view_depth = 32'($urandom_range(0, 1 << 24));
		end
		return r;
	endfunction

	function automatic req_t project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		req_t r;
		r = '0;
		r.kind = KIND_PROJECT;
		r.world_x = x; r.world_y = y; r.world_z = z;
		return r;
	endfunction

	function automatic req_t unproject_pixel(logic [15:0] px, logic [15:0] py, logic [31:0] d);
		req_t r;
		r = '1;
		r.kind = KIND_UNPROJECT;
		r.pixel_x = px; r.pixel_y = py; r.view_depth = d;
		return r;
	endfunction

	task automatic random_phase(int n);
		no_stall = ($urandom_range(0, 3) == 0);
		repeat (n) send_request(random_request());
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset camera: behind, exactly one unit deep, just short, extremes
		send_request(project_point(0, 0, 0));
		send_request(project_point(32'h00010000, 32'h00010000, 32'h00010000));
		send_request(project_point(0, 0, 32'h0000FFFF));
		send_request(project_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00010000));
		send_request(project_point(32'h80000000, 32'h80000000, 32'h00010000));
		send_request(project_point(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_request(project_point(0, 0, 32'h80000000));
		send_request(project_point(32'h00050000, 32'hFFFD0000, 32'h000A0000));
		send_request(unproject_pixel(16'h7FFF, 16'h7FFF, 32'h7FFFFFFF));
		send_request(unproject_pixel(16'h8000, 16'h8000, 32'h80000000));
		send_request(unproject_pixel(16'h8000, 16'h7FFF, 32'h7FFFFFFF));
		send_request(unproject_pixel(16'd160, 16'd100, 32'h00010000));
		send_request(unproject_pixel(16'd0, 16'd0, 32'd0));
		send_request(unproject_pixel(16'd319, 16'd199, 32'h000A0000));
		drain();

		// extreme yaw and scales
		write_camera(32'hFFFFC000, 0, 0, 0, 0, 32'h00010000, 32'h7FFFFFFF, 32'hFFFF8000);
		send_request(project_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
		send_request(project_point(0, 32'h00010000, 32'hFFFF0000));
		send_request(unproject_pixel(16'h7FFF, 16'h8000, 32'h7FFFFFFF));
		random_phase(40);

		write_camera(0, 32'h00004000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h00010000, 32'h00007FFF);
		send_request(project_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
		send_request(unproject_pixel(16'h8000, 16'h8000, 32'h80000000));
		random_phase(40);

		write_camera(0, 32'hFFFFC000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h00010000, 32'h00010000, 0);
		random_phase(40);

		write_camera(32'h00004000, 0, 0, 0, 0, 32'h00A00000, 32'h00A00000, 100);
		random_phase(60);

		repeat (6) begin
			write_camera($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
				$urandom, $urandom, $urandom, $urandom_range(32'h00010000, 32'h7FFFFFFF),
				$urandom_range(32'h00010000, 32'h7FFFFFFF), $urandom);
			random_phase(45);
		end

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: perspective_project_unproject_unit.f
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_div.sv
hw/rtl/perspective_project_unproject_unit.sv
sim/perspective_project_unproject_unit_tb.sv
